FILE: rtl/core/ptsf_pkg.sv
// ----------------------------------------------------------------------------
// Pose to start frame: shared package
// Field widths, register indexes, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package ptsf_pkg;

   localparam int ANGLE_ITERATIONS = 18;
   localparam int IterCount = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;
   localparam int IterBits = 6;

   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_POS_GAIN = 2'd2;
   localparam logic [1:0] CSR_HDG_GAIN = 2'd3;

   localparam logic signed [31:0] ORIGIN_X_RESET = 32'sd5931008;
   localparam logic signed [31:0] ORIGIN_Y_RESET = -32'sd655360;
   localparam logic signed [11:0] GAIN_RESET = 12'sd256;

   localparam logic signed [19:0] PI_Q17 = 20'sd411775;
   localparam logic signed [19:0] HALF_PI_Q17 = 20'sd205887;
   localparam logic signed [22:0] RAD_TO_DEG_Q16 = 23'sd3754936;
   localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

   // Arctangent of two to the minus index, radians Q2.17.
   function automatic logic signed [19:0] atan_entry(input logic [IterBits-1:0] idx);
      logic signed [19:0] r;
      case (idx)
         6'd0: r = 20'sd102944;
         6'd1: r = 20'sd60771;
         6'd2: r = 20'sd32110;
         6'd3: r = 20'sd16299;
         6'd4: r = 20'sd8181;
         6'd5: r = 20'sd4095;
         6'd6: r = 20'sd2048;
         6'd7: r = 20'sd1024;
         6'd8: r = 20'sd512;
         6'd9: r = 20'sd256;
         6'd10: r = 20'sd128;
         6'd11: r = 20'sd64;
         6'd12: r = 20'sd32;
         6'd13: r = 20'sd16;
         6'd14: r = 20'sd8;
         6'd15: r = 20'sd4;
         6'd16: r = 20'sd2;
         6'd17: r = 20'sd1;
         default: r = 20'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/ptsf_if.sv
// ----------------------------------------------------------------------------
// Pose to start frame: channel interfaces
// Valid/ready channels for pose requests and map results.
// ----------------------------------------------------------------------------
interface ptsf_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] track_x;
   logic signed [31:0] track_y;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   modport source (output valid, track_x, track_y, quat_x, quat_y, quat_z, quat_w,
                   input ready);
   modport sink (input valid, track_x, track_y, quat_x, quat_y, quat_z, quat_w,
                 output ready);
endinterface

interface ptsf_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] map_x;
   logic signed [31:0] map_y;
   logic signed [31:0] heading_deg;
   modport source (output valid, map_x, map_y, heading_deg, input ready);
   modport sink (input valid, map_x, map_y, heading_deg, output ready);
endinterface

FILE: rtl/core/pose_to_start_frame_top.sv
// ----------------------------------------------------------------------------
// Pose to start frame: top level
// Converts tracked poses into map coordinates relative to the first pose.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake      | Contents
//  req      | in  | valid / ready  | track_x/y, quat_x/y/z/w
//  rsp      | out | valid / ready  | map_x, map_y, heading_deg
//  csr      | in  | write enable   | index, 32-bit data
//
// A request passes through four quaternion products, one setup state, IterCount
// vectoring steps, eight product steps and one output state before the block is
// idle again. The first request also runs the rotation CORDIC for cos/sin. When
// both atan2 operands are zero the vectoring steps are skipped. A result stall
// holds the block in its output state.
// One shared add/shift datapath runs both CORDICs; one 34x23 multiplier does
// the products one per cycle. Reset is synchronous and active high. The block
// takes a new request only once the previous result has been taken.
module pose_to_start_frame_top
   import ptsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ptsf_req_if.sink    req,
   ptsf_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_QUAD  = 10'b0000000010,
      S_PREP  = 10'b0000000100,
      S_VEC   = 10'b0000001000,
      S_ROTI  = 10'b0000010000,
      S_ROT   = 10'b0000100000,
      S_TRIG  = 10'b0001000000,
      S_MUL   = 10'b0010000000,
      S_SUM   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [IterBits-1:0] iter_ff, iter_in;
   logic [3:0] step_ff, step_in;

   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic signed [11:0] pgain_ff, hgain_ff;
   logic awaiting_ff, awaiting_in;
   logic signed [31:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [19:0] start_yaw_ff, start_yaw_in;
   logic signed [17:0] start_cos_ff, start_cos_in, start_sin_ff, start_sin_in;

   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;
   // CORDIC registers: x/y 36 bits cover Q.30 rotation and the atan2 operands.
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [20:0] cz_ff, cz_in;
   logic neg_ff, neg_in;
   logic signed [19:0] yaw_ff, yaw_in;
   // Product temporaries; rotated offsets need 34 bits before the gain.
   logic signed [51:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [33:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [31:0] deg_ff, deg_in;
   logic signed [31:0] mx_ff, mx_in, my_ff, my_in, hd_ff, hd_in;

   // Shared multiplier operands.
   logic signed [33:0] mul_a;
   logic signed [22:0] mul_b;
   logic signed [56:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic signed [35:0] xs, ys;
   logic signed [20:0] at;
   logic dir;
   assign xs = cx_ff >>> iter_ff;
   assign ys = cy_ff >>> iter_ff;
   assign at = 21'(atan_entry(iter_ff));

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [17:0] sat18(input logic signed [35:0] v);
      logic signed [35:0] r;
      r = (v + 36'sd8192) >>> 14;
      if (r > 36'sd131071) return 18'sh1ffff;
      if (r < -36'sd131072) return 18'sh20000;
      return r[17:0];
   endfunction

   always_comb begin
      state_in = state_ff; iter_in = iter_ff; step_in = step_ff;
      awaiting_in = awaiting_ff;
      start_x_in = start_x_ff; start_y_in = start_y_ff; start_yaw_in = start_yaw_ff;
      start_cos_in = start_cos_ff; start_sin_in = start_sin_ff;
      tx_in = tx_ff; ty_in = ty_ff;
      qx_in = qx_ff; qy_in = qy_ff; qz_in = qz_ff; qw_in = qw_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; neg_in = neg_ff; yaw_in = yaw_ff;
      pa_in = pa_ff; pb_in = pb_ff;
      rx_in = rx_ff; ry_in = ry_ff; deg_in = deg_ff;
      mx_in = mx_ff; my_in = my_ff; hd_in = hd_ff;
      mul_a = '0; mul_b = '0; dir = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               tx_in = req.track_x; ty_in = req.track_y;
               qx_in = req.quat_x; qy_in = req.quat_y;
               qz_in = req.quat_z; qw_in = req.quat_w;
               step_in = '0;
               state_in = S_QUAD;
            end
         end
         // Four quaternion products, one per cycle, accumulated in pa/pb.
         S_QUAD: begin
            case (step_ff)
               4'd0: begin mul_a = 34'(qw_ff); mul_b = 23'(qz_ff); pa_in = 52'(mul_p); end
               4'd1: begin mul_a = 34'(qx_ff); mul_b = 23'(qy_ff); pa_in = pa_ff + 52'(mul_p); end
               4'd2: begin mul_a = 34'(qy_ff); mul_b = 23'(qy_ff); pb_in = 52'(mul_p); end
               default: begin mul_a = 34'(qz_ff); mul_b = 23'(qz_ff); pb_in = pb_ff + 52'(mul_p); end
            endcase
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd3) state_in = S_PREP;
         end
         // Form atan2 operands and fold the left half-plane.
         S_PREP: begin
            cy_in = 36'(pa_ff <<< 1);
            cx_in = 36'((52'sd1 <<< 28) - (pb_ff <<< 1));
            cz_in = '0;
            iter_in = '0;
            if (cx_in < 0) begin
               if (cy_in >= 0) begin
                  cx_in = 36'(pa_ff <<< 1); cy_in = -36'((52'sd1 <<< 28) - (pb_ff <<< 1));
                  cz_in = 21'(HALF_PI_Q17);
               end else begin
                  cx_in = -36'(pa_ff <<< 1); cy_in = 36'((52'sd1 <<< 28) - (pb_ff <<< 1));
                  cz_in = -21'(HALF_PI_Q17);
               end
            end
            if (pa_ff == 0 && pb_ff == 52'sd134217728) begin
               yaw_in = '0;
               state_in = awaiting_ff ? S_ROTI : S_MUL;
               step_in = '0;
            end else if (IterCount == 0) begin
               yaw_in = cz_in[19:0];
               state_in = awaiting_ff ? S_ROTI : S_MUL;
               step_in = '0;
            end else begin
               state_in = S_VEC;
            end
         end
         S_VEC: begin
            dir = (cy_ff > 0);
            cx_in = dir ? cx_ff + ys : cx_ff - ys;
            cy_in = dir ? cy_ff - xs : cy_ff + xs;
            cz_in = dir ? cz_ff + at : cz_ff - at;
            iter_in = iter_ff + IterBits'(1);
            if (32'(iter_ff) == IterCount - 1) begin
               yaw_in = cz_in[19:0];
               step_in = '0;
               state_in = awaiting_ff ? S_ROTI : S_MUL;
            end
         end
         // Latch the start pose and fold the yaw for the rotation CORDIC.
         S_ROTI: begin
            start_x_in = tx_ff; start_y_in = ty_ff; start_yaw_in = yaw_ff;
            awaiting_in = 1'b0;
            cx_in = 36'(CORDIC_K_Q30); cy_in = '0; iter_in = '0;
            neg_in = 1'b0;
            cz_in = 21'(yaw_ff);
            if (yaw_ff > HALF_PI_Q17) begin
               cz_in = 21'(yaw_ff) - 21'(PI_Q17); neg_in = 1'b1;
            end else if (yaw_ff < -HALF_PI_Q17) begin
               cz_in = 21'(yaw_ff) + 21'(PI_Q17); neg_in = 1'b1;
            end
            state_in = (IterCount == 0) ? S_TRIG : S_ROT;
         end
         S_ROT: begin
            dir = (cz_ff >= 0);
            cx_in = dir ? cx_ff - ys : cx_ff + ys;
            cy_in = dir ? cy_ff + xs : cy_ff - xs;
            cz_in = dir ? cz_ff - at : cz_ff + at;
            iter_in = iter_ff + IterBits'(1);
            if (32'(iter_ff) == IterCount - 1) state_in = S_TRIG;
         end
         S_TRIG: begin
            start_cos_in = sat18(neg_ff ? -cx_ff : cx_ff);
            start_sin_in = sat18(neg_ff ? -cy_ff : cy_ff);
            step_in = '0;
            state_in = S_MUL;
         end
         // Products in sequence: rotation terms, gains and degree scaling.
         S_MUL: begin
            case (step_ff)
               4'd0: begin
                  mul_a = 34'(start_x_ff) - 34'(tx_ff); mul_b = 23'(start_cos_ff);
                  pa_in = 52'(mul_p);
               end
               4'd1: begin
                  mul_a = 34'(start_y_ff) - 34'(ty_ff); mul_b = 23'(start_sin_ff);
                  // -(a) rounded half up: floor((-a + 2^15) / 2^16)
                  rx_in = 34'((-(pa_ff + 52'(mul_p)) + 52'sd32768) >>> 16);
               end
               4'd2: begin
                  mul_a = 34'(start_x_ff) - 34'(tx_ff); mul_b = 23'(start_sin_ff);
                  pb_in = 52'(mul_p);
               end
               4'd3: begin
                  mul_a = 34'(start_y_ff) - 34'(ty_ff); mul_b = 23'(start_cos_ff);
                  ry_in = 34'((pb_ff - 52'(mul_p) + 52'sd32768) >>> 16);
               end
               4'd4: begin
                  mul_a = rx_ff; mul_b = 23'(pgain_ff);
                  mx_in = sat32(64'(origin_x_ff) + 64'((mul_p + 57'sd128) >>> 8));
               end
               4'd5: begin
                  mul_a = ry_ff; mul_b = 23'(pgain_ff);
                  my_in = sat32(64'(origin_y_ff) + 64'((mul_p + 57'sd128) >>> 8));
               end
               4'd6: begin
                  mul_a = 34'(yaw_ff) - 34'(start_yaw_ff); mul_b = RAD_TO_DEG_Q16;
                  deg_in = 32'((mul_p + 57'sd65536) >>> 17);
               end
               default: begin
                  mul_a = 34'(deg_ff); mul_b = 23'(hgain_ff);
                  hd_in = sat32(-64'((mul_p + 57'sd128) >>> 8));
                  state_in = S_OUT;
               end
            endcase
            step_in = step_ff + 4'd1;
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.map_x = mx_ff;
   assign rsp.map_y = my_ff;
   assign rsp.heading_deg = hd_ff;

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         awaiting_ff <= 1'b1;
         start_x_ff <= '0; start_y_ff <= '0; start_yaw_ff <= '0;
         start_cos_ff <= '0; start_sin_ff <= '0;
         origin_x_ff <= ORIGIN_X_RESET; origin_y_ff <= ORIGIN_Y_RESET;
         pgain_ff <= GAIN_RESET; hgain_ff <= GAIN_RESET;
      end else begin
         state_ff <= state_in;
         awaiting_ff <= awaiting_in;
         start_x_ff <= start_x_in; start_y_ff <= start_y_in; start_yaw_ff <= start_yaw_in;
         start_cos_ff <= start_cos_in; start_sin_ff <= start_sin_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
               CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
               CSR_POS_GAIN: pgain_ff <= csr_wdata[11:0];
               CSR_HDG_GAIN: hgain_ff <= csr_wdata[11:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      iter_ff <= iter_in; step_ff <= step_in;
      tx_ff <= tx_in; ty_ff <= ty_in;
      qx_ff <= qx_in; qy_ff <= qy_in; qz_ff <= qz_in; qw_ff <= qw_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; neg_ff <= neg_in; yaw_ff <= yaw_in;
      pa_ff <= pa_in; pb_ff <= pb_in;
      rx_ff <= rx_in; ry_ff <= ry_in; deg_ff <= deg_in;
      mx_ff <= mx_in; my_ff <= my_in; hd_ff <= hd_in;
   end

   // A result is only offered after the start pose has been latched.
   a_start_latched: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !awaiting_ff) else $error("result before start latched");
   // Handshake sides are never open together.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready and valid together");
   // A taken result returns the block to idle.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready |=> req.ready) else $error("no return to idle");

endmodule
